### design/usbreq_pkg.sv
// ---------------------------------------------------------------------------
// usbreq_pkg : shared types and codes for the standard request handler
// Request decode classes, result codes and the front-to-back queue entry.
// ---------------------------------------------------------------------------
package usbreq_pkg;

    localparam logic [1:0] KIND_SETUP = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_POLL  = 2'd2;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STALL = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_REPLY = 3'd3;
    localparam logic [2:0] ACT_DESC  = 3'd4;

    localparam logic [1:0] ST_DEFAULT    = 2'd0;
    localparam logic [1:0] ST_ADDRESSED  = 2'd1;
    localparam logic [1:0] ST_CONFIGURED = 2'd2;

    localparam logic [4:0] RCP_DEVICE    = 5'd0;
    localparam logic [4:0] RCP_INTERFACE = 5'd1;
    localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

    localparam logic [1:0] EPOP_NONE   = 2'd0;
    localparam logic [1:0] EPOP_SET    = 2'd1;
    localparam logic [1:0] EPOP_CLEAR  = 2'd2;
    localparam logic [1:0] EPOP_CONFIG = 2'd3;

    localparam logic [2:0] CFG_OWN_POWER  = 3'd0;
    localparam logic [2:0] CFG_DEVICE_LEN = 3'd1;
    localparam logic [2:0] CFG_CONFIG_LEN = 3'd2;
    localparam logic [2:0] CFG_LANG_LEN   = 3'd3;
    localparam logic [2:0] CFG_STR1_LEN   = 3'd4;
    localparam logic [2:0] CFG_STR2_LEN   = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_IGNORE,
        OP_BUS_RESET,
        OP_POLL,
        OP_GET_STATUS,
        OP_CLEAR_FEATURE,
        OP_SET_FEATURE,
        OP_SET_ADDRESS,
        OP_GET_DESC,
        OP_GET_CONFIG,
        OP_SET_CONFIG,
        OP_GET_IFACE,
        OP_READ_SEGMENT,
        OP_READ_SWITCH,
        OP_READ_BARGRAPH,
        OP_WRITE_BARGRAPH,
        OP_WRITE_SEGMENT
    } op_t;

    // Unknown codes and set interface carry stall_only; the speed query
    // carries speed_query.
    typedef struct packed {
        op_t         op;
        logic        stall_only;
        logic        speed_query;
        logic [4:0]  rcp;
        logic [15:0] value;
        logic        idx_zero;
        logic [3:0]  ep;
        logic [7:0]  data;
        logic [7:0]  desc_len;
        logic [3:0]  desc_id;
        logic        desc_ok;
    } entry_t;

endpackage

### design/usbreq_front.sv
// ---------------------------------------------------------------------------
// usbreq_front : request classifier
// Decodes one input beat into an operation class and resolves descriptor
// selection and wLength clamping against the length registers.
// ---------------------------------------------------------------------------
module usbreq_front
    import usbreq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic [1:0]  kind,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] value_word,
    input  logic [15:0] index_word,
    input  logic [15:0] length_word,
    input  logic [7:0]  data_byte,
    output entry_t      entry,
    output logic        own_power
);

    logic       own_power_reg;
    logic [7:0] dev_len_reg, cfg_len_reg, lang_len_reg, str1_len_reg, str2_len_reg;
    logic [7:0] base_len;
    logic [7:0] idx8;

    assign cfg_ready = 1'b1;
    assign own_power = own_power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_power_reg <= 1'b0;
            dev_len_reg   <= 8'd18;
            cfg_len_reg   <= 8'd39;
            lang_len_reg  <= 8'd4;
            str1_len_reg  <= 8'd0;
            str2_len_reg  <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OWN_POWER:  own_power_reg <= cfg_data[0];
                CFG_DEVICE_LEN: dev_len_reg   <= cfg_data;
                CFG_CONFIG_LEN: cfg_len_reg   <= cfg_data;
                CFG_LANG_LEN:   lang_len_reg  <= cfg_data;
                CFG_STR1_LEN:   str1_len_reg  <= cfg_data;
                CFG_STR2_LEN:   str2_len_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign idx8 = value_word[7:0];

    always_comb
    begin
        entry             = '0;
        entry.op          = OP_IGNORE;
        entry.rcp         = request_type[4:0];
        entry.value       = value_word;
        entry.idx_zero    = (index_word == 16'd0);
        entry.ep          = index_word[3:0];
        entry.data        = data_byte;
        base_len          = 8'd0;
        entry.desc_ok     = 1'b1;
        unique case (value_word[15:8])
            8'd1: begin entry.desc_id = 4'd0; base_len = dev_len_reg; end
            8'd2: begin entry.desc_id = 4'd1; base_len = cfg_len_reg; end
            8'd3:
            begin
                entry.desc_id = 4'd2 + idx8[3:0];
                if (idx8 == 8'd0)      base_len = lang_len_reg;
                else if (idx8 == 8'd1) base_len = str1_len_reg;
                else if (idx8 == 8'd2) base_len = str2_len_reg;
                else entry.desc_ok = 1'b0;
            end
            8'd4:
            begin
                entry.desc_id = 4'd5;
                base_len      = 8'd9;
                entry.desc_ok = (idx8 == 8'd0);
            end
            8'd5:
            begin
                base_len = 8'd7;
                if (idx8 == 8'd1)      entry.desc_id = 4'd6;
                else if (idx8 == 8'd4) entry.desc_id = 4'd7;
                else if (idx8 == 8'd6) entry.desc_id = 4'd8;
                else entry.desc_ok = 1'b0;
            end
            default: entry.desc_ok = 1'b0;
        endcase
        entry.desc_len = ({8'd0, base_len} > length_word) ? length_word[7:0] : base_len;

        unique case (kind)
            KIND_RESET: entry.op = OP_BUS_RESET;
            KIND_POLL:  entry.op = OP_POLL;
            KIND_SETUP:
            begin
                unique case (request_code)
                    8'h00: entry.op = OP_GET_STATUS;
                    8'h01: entry.op = OP_CLEAR_FEATURE;
                    8'h03: entry.op = OP_SET_FEATURE;
                    8'h05: entry.op = OP_SET_ADDRESS;
                    8'h06: entry.op = OP_GET_DESC;
                    8'h08: entry.op = OP_GET_CONFIG;
                    8'h09: entry.op = OP_SET_CONFIG;
                    8'h0A: entry.op = OP_GET_IFACE;
                    8'hD4: entry.op = OP_READ_SEGMENT;
                    8'hD6: entry.op = OP_READ_SWITCH;
                    8'hD7: entry.op = OP_READ_BARGRAPH;
                    8'hD8: entry.op = OP_WRITE_BARGRAPH;
                    8'hD9: entry.speed_query = 1'b1;
                    8'hDB: entry.op = OP_WRITE_SEGMENT;
                    default: entry.stall_only = 1'b1;
                endcase
            end
            default: entry.op = OP_IGNORE;
        endcase
    end

endmodule

### design/usbreq_queue.sv
// ---------------------------------------------------------------------------
// usbreq_queue : two-entry queue between classifier and executor
// Registered FIFO; full and empty from a fill count.
// ---------------------------------------------------------------------------
module usbreq_queue
    import usbreq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    entry_t     slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### design/usbreq_back.sv
// ---------------------------------------------------------------------------
// usbreq_back : request executor
// Holds device state, wakeup, halt flags and vendor bytes; builds the result
// beat into an output register.
// ---------------------------------------------------------------------------
module usbreq_back
    import usbreq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  entry_t      head,
    output logic        pop,
    input  logic        own_power,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [1:0]  reply_len,
    output logic [7:0]  reply_low,
    output logic [7:0]  reply_high,
    output logic [3:0]  descriptor_id,
    output logic [7:0]  descriptor_len,
    output logic [6:0]  new_address,
    output logic        address_pending,
    output logic [1:0]  endpoint_op,
    output logic [3:0]  endpoint_num,
    output logic [1:0]  device_state_out
);

    logic [1:0] state_reg, state_next;
    logic       wake_reg, wake_next;
    logic [2:0] halt_reg, halt_next;
    logic [7:0] bar_reg, bar_next, seg_reg, seg_next, sw_reg, sw_next;
    logic       valid_reg;

    logic [2:0] act;
    logic [1:0] rlen;
    logic [7:0] rlo;
    logic [3:0] did;
    logic [7:0] dlen;
    logic [6:0] addr;
    logic       apend;
    logic [1:0] epop;
    logic [3:0] epn;
    logic       hb_ok;
    logic [1:0] hb;
    logic [7:0] dev_word;
    logic       is_set;

    assign pop       = head_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;

    always_comb
    begin
        hb_ok = 1'b1;
        hb    = 2'd0;
        unique case (head.ep)
            4'd1: hb = 2'd0;
            4'd4: hb = 2'd1;
            4'd6: hb = 2'd2;
            default: hb_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        wake_next  = wake_reg;
        halt_next  = halt_reg;
        bar_next   = bar_reg;
        seg_next   = seg_reg;
        sw_next    = sw_reg;
        act = ACT_NONE; rlen = 2'd0; rlo = 8'd0; did = 4'd0; dlen = 8'd0;
        addr = 7'd0; apend = 1'b0; epop = EPOP_NONE; epn = 4'd0;
        dev_word = {6'd0, wake_reg, own_power};
        is_set   = (head.op == OP_SET_FEATURE);
        if (head.stall_only)
        begin
            act = ACT_STALL;
        end
        else if (head.speed_query)
        begin
            act = ACT_REPLY; rlen = 2'd1;
        end
        else
        begin
            unique case (head.op)
                OP_IGNORE, OP_BUS_RESET:
                begin
                    if (head.op == OP_BUS_RESET)
                    begin
                        state_next = ST_DEFAULT;
                        wake_next  = 1'b0;
                    end
                end
                OP_POLL:
                begin
                    act = ACT_REPLY; rlen = 2'd1; rlo = sw_reg;
                    sw_next = sw_reg + 8'd1;
                end
                OP_GET_STATUS:
                begin
                    act = ACT_STALL;
                    if (state_reg == ST_ADDRESSED)
                    begin
                        if (head.idx_zero && head.rcp == RCP_DEVICE)
                        begin
                            act = ACT_REPLY; rlen = 2'd2; rlo = dev_word;
                        end
                        else if (head.idx_zero && head.rcp == RCP_ENDPOINT)
                        begin
                            act = ACT_REPLY; rlen = 2'd2;
                        end
                    end
                    else if (state_reg == ST_CONFIGURED)
                    begin
                        if (head.rcp == RCP_DEVICE)
                        begin
                            act = ACT_REPLY; rlen = 2'd2; rlo = dev_word;
                        end
                        else if (head.rcp == RCP_ENDPOINT)
                        begin
                            if (head.ep == 4'd0)
                            begin
                                act = ACT_REPLY; rlen = 2'd2;
                            end
                            else if (hb_ok)
                            begin
                                act = ACT_REPLY; rlen = 2'd2;
                                rlo = {7'd0, halt_reg[hb]};
                            end
                        end
                        else if (head.rcp == RCP_INTERFACE && head.idx_zero)
                        begin
                            act = ACT_REPLY; rlen = 2'd2;
                        end
                    end
                end
                OP_CLEAR_FEATURE, OP_SET_FEATURE:
                begin
                    if (state_reg == ST_ADDRESSED)
                    begin
                        act = ACT_ACK;
                        if (!head.idx_zero) act = ACT_STALL;
                        else if (head.rcp == RCP_DEVICE)
                        begin
                            if (head.value != 16'd1) act = ACT_STALL;
                            else wake_next = is_set;
                        end
                        else if (head.rcp == RCP_ENDPOINT && head.value == 16'd0)
                            act = ACT_STALL;
                    end
                    else if (state_reg == ST_CONFIGURED)
                    begin
                        act = ACT_ACK;
                        if (head.rcp == RCP_DEVICE)
                        begin
                            if (head.value != 16'd1) act = ACT_STALL;
                            else wake_next = is_set;
                        end
                        else if (head.rcp == RCP_ENDPOINT)
                        begin
                            if (head.value != 16'd0 || !hb_ok) act = ACT_STALL;
                            else
                            begin
                                halt_next[hb] = is_set;
                                epop = is_set ? EPOP_SET : EPOP_CLEAR;
                                epn  = head.ep;
                            end
                        end
                    end
                end
                OP_SET_ADDRESS:
                begin
                    addr  = head.value[6:0];
                    state_next = (addr != 7'd0) ? ST_ADDRESSED : ST_DEFAULT;
                    act   = ACT_ACK;
                    apend = 1'b1;
                end
                OP_GET_DESC:
                begin
                    if (head.desc_ok)
                    begin
                        act = ACT_DESC; did = head.desc_id; dlen = head.desc_len;
                    end
                    else act = ACT_STALL;
                end
                OP_GET_CONFIG:
                begin
                    if (state_reg == ST_ADDRESSED)
                    begin
                        act = ACT_REPLY; rlen = 2'd1;
                    end
                    else if (state_reg == ST_CONFIGURED)
                    begin
                        act = ACT_REPLY; rlen = 2'd1; rlo = 8'd1;
                    end
                    else act = ACT_STALL;
                end
                OP_SET_CONFIG:
                begin
                    act = ACT_STALL;
                    if (state_reg != ST_DEFAULT && head.value == 16'd1)
                    begin
                        act = ACT_ACK;
                        if (state_reg == ST_ADDRESSED)
                        begin
                            state_next = ST_CONFIGURED;
                            halt_next  = 3'd0;
                            epop       = EPOP_CONFIG;
                        end
                    end
                    else if (state_reg != ST_DEFAULT && head.value == 16'd0)
                    begin
                        act = ACT_ACK;
                        state_next = ST_ADDRESSED;
                    end
                end
                OP_GET_IFACE:
                begin
                    if (state_reg == ST_CONFIGURED && head.idx_zero)
                    begin
                        act = ACT_REPLY; rlen = 2'd1;
                    end
                    else act = ACT_STALL;
                end
                OP_READ_SEGMENT:  begin act = ACT_REPLY; rlen = 2'd1; rlo = seg_reg; end
                OP_READ_SWITCH:   begin act = ACT_REPLY; rlen = 2'd1; rlo = sw_reg; end
                OP_READ_BARGRAPH: begin act = ACT_REPLY; rlen = 2'd1; rlo = bar_reg; end
                OP_WRITE_BARGRAPH: begin bar_next = head.data; act = ACT_ACK; end
                OP_WRITE_SEGMENT:  begin seg_next = head.data; act = ACT_ACK; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action           <= act;
            reply_len        <= rlen;
            reply_low        <= rlo;
            reply_high       <= 8'd0;
            descriptor_id    <= did;
            descriptor_len   <= dlen;
            new_address      <= addr;
            address_pending  <= apend;
            endpoint_op      <= epop;
            endpoint_num     <= epn;
            device_state_out <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DEFAULT;
            wake_reg  <= 1'b0;
            halt_reg  <= 3'd0;
            bar_reg   <= 8'd0;
            seg_reg   <= 8'd0;
            sw_reg    <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg <= state_next;
                wake_reg  <= wake_next;
                halt_reg  <= halt_next;
                bar_reg   <= bar_next;
                seg_reg   <= seg_next;
                sw_reg    <= sw_next;
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

### design/usb_standard_request_handler.sv
// ---------------------------------------------------------------------------
// usb_standard_request_handler : chapter 9 request handler top level
// A classifier takes one beat per cycle into a two-entry queue while
// in_stall is low; the executor retires one beat per cycle into an output
// register while out_stall is low. Sustained rate is one item per cycle
// when neither side stalls. An accepted beat passes through a queue slot
// and then the output register. Configuration is always ready.
module usb_standard_request_handler
    import usbreq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] value_word,
    input  logic [15:0] index_word,
    input  logic [15:0] length_word,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [1:0]  reply_len,
    output logic [7:0]  reply_low,
    output logic [7:0]  reply_high,
    output logic [3:0]  descriptor_id,
    output logic [7:0]  descriptor_len,
    output logic [6:0]  new_address,
    output logic        address_pending,
    output logic [1:0]  endpoint_op,
    output logic [3:0]  endpoint_num,
    output logic [1:0]  device_state_out
);

    entry_t entry, head;
    logic   full, not_empty, pop, own_power;

    assign in_stall = full;

    usbreq_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .kind, .request_type, .request_code, .value_word, .index_word,
        .length_word, .data_byte, .entry, .own_power
    );

    usbreq_queue u_queue (
        .clk, .rst_n, .push(in_valid && !full), .push_entry(entry), .full,
        .pop, .not_empty, .head
    );

    usbreq_back u_back (
        .clk, .rst_n, .head_valid(not_empty), .head, .pop, .own_power,
        .out_valid, .out_stall, .action, .reply_len, .reply_low, .reply_high,
        .descriptor_id, .descriptor_len, .new_address, .address_pending,
        .endpoint_op, .endpoint_num, .device_state_out
    );

endmodule

### design/usbreq_checker.sv
// ---------------------------------------------------------------------------
// usbreq_checker : port-level checks for the request handler
// Output beat consistency and handshake hold.
// ---------------------------------------------------------------------------
module usbreq_checker
    import usbreq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] action,
    input logic [1:0] reply_len,
    input logic [7:0] descriptor_len,
    input logic [1:0] device_state_out
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action))
        else $error("stalled result changed");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_REPLY |-> reply_len == 2'd0)
        else $error("reply length without reply");

    a_desc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_DESC |-> descriptor_len == 8'd0)
        else $error("descriptor length without descriptor");

    a_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> device_state_out != 2'd3)
        else $error("bad device state");

endmodule

bind usb_standard_request_handler usbreq_checker u_checker (
    .clk, .rst_n, .out_valid, .out_stall, .action, .reply_len,
    .descriptor_len, .device_state_out
);

### verif/tb_usb_standard_request_handler.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_usb_standard_request_handler : self-checking bench for the request handler
// Directed setup sequences, bus resets and polls, then random enumeration-like
// traffic with noise, under random valid gaps and result stalls. A behavioural
// model of the device state predicts every result beat, checked field by field.
// ---------------------------------------------------------------------------
module tb_usb_standard_request_handler;
    import usbreq_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        logic [7:0]  data;
    } request_t;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] rlen;
        logic [7:0] rlow;
        logic [7:0] rhigh;
        logic [3:0] did;
        logic [7:0] dlen;
        logic [6:0] addr;
        logic       apend;
        logic [1:0] epop;
        logic [3:0] epnum;
        logic [1:0] dstate;
    } outcome_t;

    localparam logic [7:0] REQ_GET_STATUS  = 8'd0;
    localparam logic [7:0] REQ_CLR_FEATURE = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
    localparam logic [7:0] REQ_GET_DESC    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG  = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;
    localparam logic [7:0] REQ_GET_IFACE   = 8'd10;
    localparam logic [7:0] REQ_SET_IFACE   = 8'd11;
    localparam logic [7:0] VND_RD_SEGMENT  = 8'hD4;
    localparam logic [7:0] VND_RD_SWITCH   = 8'hD6;
    localparam logic [7:0] VND_RD_BARGRAPH = 8'hD7;
    localparam logic [7:0] VND_WR_BARGRAPH = 8'hD8;
    localparam logic [7:0] VND_RD_SPEED    = 8'hD9;
    localparam logic [7:0] VND_WR_SEGMENT  = 8'hDB;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  action;
    logic [1:0]  reply_len;
    logic [7:0]  reply_low;
    logic [7:0]  reply_high;
    logic [3:0]  descriptor_id;
    logic [7:0]  descriptor_len;
    logic [6:0]  new_address;
    logic        address_pending;
    logic [1:0]  endpoint_op;
    logic [3:0]  endpoint_num;
    logic [1:0]  device_state_out;

    // device model
    logic       mdl_own_power;
    logic [7:0] mdl_dev_len, mdl_cfg_len, mdl_lang_len, mdl_str1_len, mdl_str2_len;
    logic [1:0] mdl_state;
    logic       mdl_wakeup;
    logic [2:0] mdl_halts;
    logic [7:0] mdl_bargraph, mdl_segment, mdl_switch;

    outcome_t expected_beats[$];
    int       errors;
    int       idle_pct;
    int       quiet_cycles;

    usb_standard_request_handler uut (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int halt_pos(logic [3:0] ep);
        case (ep)
            4'd1: return 0;
            4'd4: return 1;
            4'd6: return 2;
            default: return -1;
        endcase
    endfunction

    function automatic outcome_t reply_of(logic [1:0] n, logic [7:0] lo);
        outcome_t r;
        r = '0;
        r.action = ACT_REPLY;
        r.rlen = n;
        r.rlow = lo;
        return r;
    endfunction

    function automatic outcome_t predict_outcome(request_t q);
        outcome_t   r;
        logic [4:0] rcp;
        logic [3:0] ep;
        logic [7:0] status_byte;
        logic [7:0] dtype, dindex;
        logic [7:0] dl;
        int         b;
        r = '0;
        rcp = q.rtype[4:0];
        ep = q.index[3:0];
        status_byte = {6'd0, mdl_wakeup, mdl_own_power};
        b = halt_pos(ep);
        if (q.kind == KIND_RESET)
        begin
            mdl_state = ST_DEFAULT;
            mdl_wakeup = 1'b0;
        end
        else if (q.kind == KIND_POLL)
        begin
            r = reply_of(2'd1, mdl_switch);
            mdl_switch = mdl_switch + 8'd1;
        end
        else if (q.kind == KIND_SETUP)
        begin
            case (q.code)
                REQ_GET_STATUS:
                    if (mdl_state == ST_ADDRESSED)
                    begin
                        if (q.index == 0 && rcp == RCP_DEVICE) r = reply_of(2'd2, status_byte);
                        else if (q.index == 0 && rcp == RCP_ENDPOINT) r = reply_of(2'd2, 8'd0);
                        else r.action = ACT_STALL;
                    end
                    else if (mdl_state == ST_CONFIGURED)
                    begin
                        if (rcp == RCP_DEVICE) r = reply_of(2'd2, status_byte);
                        else if (rcp == RCP_ENDPOINT)
                        begin
                            if (ep == 0) r = reply_of(2'd2, 8'd0);
                            else if (b < 0) r.action = ACT_STALL;
                            else r = reply_of(2'd2, {7'd0, mdl_halts[b]});
                        end
                        else if (rcp == RCP_INTERFACE && q.index == 0) r = reply_of(2'd2, 8'd0);
                        else r.action = ACT_STALL;
                    end
                    else r.action = ACT_STALL;
                REQ_CLR_FEATURE, REQ_SET_FEATURE:
                    if (mdl_state == ST_ADDRESSED)
                    begin
                        if (q.index != 0) r.action = ACT_STALL;
                        else if (rcp == RCP_DEVICE)
                        begin
                            if (q.value != 1) r.action = ACT_STALL;
                            else
                            begin
                                mdl_wakeup = (q.code == REQ_SET_FEATURE);
                                r.action = ACT_ACK;
                            end
                        end
                        else if (rcp == RCP_ENDPOINT && q.value == 0) r.action = ACT_STALL;
                        else r.action = ACT_ACK;
                    end
                    else if (mdl_state == ST_CONFIGURED)
                    begin
                        if (rcp == RCP_DEVICE)
                        begin
                            if (q.value != 1) r.action = ACT_STALL;
                            else
                            begin
                                mdl_wakeup = (q.code == REQ_SET_FEATURE);
                                r.action = ACT_ACK;
                            end
                        end
                        else if (rcp == RCP_ENDPOINT)
                        begin
                            if (q.value != 0 || b < 0) r.action = ACT_STALL;
                            else
                            begin
                                mdl_halts[b] = (q.code == REQ_SET_FEATURE);
                                r.epop = (q.code == REQ_SET_FEATURE) ? EPOP_SET : EPOP_CLEAR;
                                r.epnum = ep;
                                r.action = ACT_ACK;
                            end
                        end
                        else r.action = ACT_ACK;
                    end
                REQ_SET_ADDRESS:
                begin
                    mdl_state = (q.value[6:0] != 0) ? ST_ADDRESSED : ST_DEFAULT;
                    r.action = ACT_ACK;
                    r.addr = q.value[6:0];
                    r.apend = 1'b1;
                end
                REQ_GET_DESC:
                begin
                    dtype = q.value[15:8];
                    dindex = q.value[7:0];
                    r.action = ACT_DESC;
                    dl = 8'd0;
                    case (dtype)
                        8'd1: begin r.did = 4'd0; dl = mdl_dev_len; end
                        8'd2: begin r.did = 4'd1; dl = mdl_cfg_len; end
                        8'd3:
                            if (dindex == 0) begin r.did = 4'd2; dl = mdl_lang_len; end
                            else if (dindex == 1) begin r.did = 4'd3; dl = mdl_str1_len; end
                            else if (dindex == 2) begin r.did = 4'd4; dl = mdl_str2_len; end
                            else r.action = ACT_STALL;
                        8'd4:
                            if (dindex == 0) begin r.did = 4'd5; dl = 8'd9; end
                            else r.action = ACT_STALL;
                        8'd5:
                            if (dindex == 1) begin r.did = 4'd6; dl = 8'd7; end
                            else if (dindex == 4) begin r.did = 4'd7; dl = 8'd7; end
                            else if (dindex == 6) begin r.did = 4'd8; dl = 8'd7; end
                            else r.action = ACT_STALL;
                        default: r.action = ACT_STALL;
                    endcase
                    if (r.action == ACT_STALL) r.did = 4'd0;
                    else r.dlen = ({8'd0, dl} > q.length) ? q.length[7:0] : dl;
                end
                REQ_GET_CONFIG:
                    if (mdl_state == ST_ADDRESSED) r = reply_of(2'd1, 8'd0);
                    else if (mdl_state == ST_CONFIGURED) r = reply_of(2'd1, 8'd1);
                    else r.action = ACT_STALL;
                REQ_SET_CONFIG:
                    if (mdl_state == ST_ADDRESSED && q.value == 1)
                    begin
                        mdl_state = ST_CONFIGURED;
                        mdl_halts = 3'd0;
                        r.epop = EPOP_CONFIG;
                        r.action = ACT_ACK;
                    end
                    else if (mdl_state == ST_ADDRESSED && q.value == 0) r.action = ACT_ACK;
                    else if (mdl_state == ST_CONFIGURED && q.value == 1) r.action = ACT_ACK;
                    else if (mdl_state == ST_CONFIGURED && q.value == 0)
                    begin
                        mdl_state = ST_ADDRESSED;
                        r.action = ACT_ACK;
                    end
                    else r.action = ACT_STALL;
                REQ_GET_IFACE:
                    if (mdl_state == ST_CONFIGURED && q.index == 0) r = reply_of(2'd1, 8'd0);
                    else r.action = ACT_STALL;
                VND_RD_SEGMENT:  r = reply_of(2'd1, mdl_segment);
                VND_RD_SWITCH:   r = reply_of(2'd1, mdl_switch);
                VND_RD_BARGRAPH: r = reply_of(2'd1, mdl_bargraph);
                VND_RD_SPEED:    r = reply_of(2'd1, 8'd0);
                VND_WR_BARGRAPH:
                begin
                    mdl_bargraph = q.data;
                    r.action = ACT_ACK;
                end
                VND_WR_SEGMENT:
                begin
                    mdl_segment = q.data;
                    r.action = ACT_ACK;
                end
                default: r.action = ACT_STALL;
            endcase
        end
        r.dstate = mdl_state;
        return r;
    endfunction

    task automatic send_request(request_t q);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid     <= 1'b1;
        kind         <= q.kind;
        request_type <= q.rtype;
        request_code <= q.code;
        value_word   <= q.value;
        index_word   <= q.index;
        length_word  <= q.length;
        data_byte    <= q.data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_beats.push_back(predict_outcome(q));
    endtask

    task automatic send_setup(logic [7:0] rt, logic [7:0] code, logic [15:0] val,
                              logic [15:0] idx, logic [15:0] len, logic [7:0] dat);
        send_request({KIND_SETUP, rt, code, val, idx, len, dat});
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OWN_POWER:  mdl_own_power = val[0];
            CFG_DEVICE_LEN: mdl_dev_len = val;
            CFG_CONFIG_LEN: mdl_cfg_len = val;
            CFG_LANG_LEN:   mdl_lang_len = val;
            CFG_STR1_LEN:   mdl_str1_len = val;
            CFG_STR2_LEN:   mdl_str2_len = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic sp, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                 logic [7:0] d, logic [7:0] e);
        drain_results();
        write_register(CFG_OWN_POWER, {7'd0, sp});
        write_register(CFG_DEVICE_LEN, a);
        write_register(CFG_CONFIG_LEN, b);
        write_register(CFG_LANG_LEN, c);
        write_register(CFG_STR1_LEN, d);
        write_register(CFG_STR2_LEN, e);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // default state: get status stalls, set feature gets no response; vendor, address and descriptors are served
        send_setup(8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 8'h00);
        send_setup(8'h00, REQ_SET_FEATURE, 16'h0001, 16'h0000, 16'h0000, 8'h00);
        send_setup(8'h80, REQ_GET_DESC, 16'h0100, 16'h0000, 16'hFFFF, 8'h00);
        send_setup(8'h80, REQ_GET_DESC, 16'h0200, 16'h0000, 16'h0009, 8'h00);
        send_setup(8'h40, VND_WR_BARGRAPH, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
        send_setup(8'h40, VND_WR_SEGMENT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hA5);
        send_setup(8'hC0, VND_RD_BARGRAPH, 16'h0000, 16'h0000, 16'h0001, 8'h00);
        send_setup(8'hC0, VND_RD_SEGMENT, 16'h0000, 16'h0000, 16'h0001, 8'h00);
        send_setup(8'hC0, VND_RD_SPEED, 16'h0000, 16'h0000, 16'h0001, 8'h00);
        send_request({KIND_POLL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
        send_setup(8'hC0, VND_RD_SWITCH, 16'h0000, 16'h0000, 16'h0001, 8'h00);
        send_setup(8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000, 8'h00);
        send_setup(8'h00, REQ_SET_FEATURE, 16'h0001, 16'h0000, 16'h0000, 8'h00);
        send_setup(8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002, 8'h00);
        send_setup(8'h02, REQ_CLR_FEATURE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_setup(8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0001, 8'h00);
        send_setup(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000, 8'h00);
        send_setup(8'h02, REQ_SET_FEATURE, 16'h0000, 16'h0086, 16'h0000, 8'h00);
        send_setup(8'h82, REQ_GET_STATUS, 16'h0000, 16'h0006, 16'h0002, 8'h00);
        send_setup(8'h81, REQ_GET_IFACE, 16'h0000, 16'h0000, 16'h0001, 8'h00);
        send_setup(8'h01, REQ_SET_IFACE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_setup(8'h80, 8'h77, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_request({KIND_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00});
        send_request({2'd3, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00});
    endtask

    function automatic request_t random_request();
        request_t   q;
        logic [7:0] codes[15];
        int         sel;
        codes = '{REQ_GET_STATUS, REQ_CLR_FEATURE, REQ_SET_FEATURE, REQ_SET_ADDRESS,
                  REQ_GET_DESC, REQ_GET_CONFIG, REQ_SET_CONFIG, REQ_GET_IFACE,
                  REQ_SET_IFACE, VND_RD_SEGMENT, VND_RD_SWITCH, VND_RD_BARGRAPH,
                  VND_WR_BARGRAPH, VND_RD_SPEED, VND_WR_SEGMENT};
        q.kind   = KIND_SETUP;
        q.rtype  = {3'($urandom_range(7)), $urandom_range(2) == 0 ? 5'($urandom) :
                    5'($urandom_range(2))};
        q.code   = codes[$urandom_range(14)];
        q.value  = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2));
        q.index  = $urandom_range(3) == 0 ? 16'($urandom) :
                   {12'd0, 4'($urandom_range(1) ? $urandom_range(7) : 0)};
        q.length = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(300));
        q.data   = 8'($urandom);
        sel = $urandom_range(99);
        if (q.code == REQ_GET_DESC)
            q.value = {8'($urandom_range(6)), $urandom_range(4) == 0 ? 8'($urandom) :
                       8'($urandom_range(6))};
        else if (q.code == REQ_SET_ADDRESS && sel < 80)
            q.value = {9'($urandom), 7'($urandom_range(127, 1))};
        if (sel < 4) q.code = 8'($urandom);
        else if (sel < 8) q.kind = KIND_RESET;
        else if (sel < 13) q.kind = KIND_POLL;
        else if (sel < 15) q.kind = 2'd3;
        return q;
    endfunction

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    task automatic test_enumeration(int rounds);
        for (int i = 0; i < rounds; i++)
        begin
            send_setup(8'h00, REQ_SET_ADDRESS, {9'($urandom), 7'($urandom_range(127, 1))},
                       16'h0000, 16'h0000, 8'h00);
            send_setup(8'h00, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000, 8'h00);
            test_random(12);
        end
    endtask

    task automatic test_pause();
        send_setup(8'h02, REQ_SET_FEATURE, 16'h0000, 16'h0001, 16'h0000, 8'h00);
        drain_results();
        send_setup(8'h82, REQ_GET_STATUS, 16'h0000, 16'h0001, 16'h0002, 8'h00);
    endtask

    // result checker
    always @(posedge clk)
    begin
        outcome_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {action, reply_len, reply_low, reply_high, descriptor_id, descriptor_len,
                   new_address, address_pending, endpoint_op, endpoint_num, device_state_out};
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.action !== want.action || got.rlen !== want.rlen ||
                    got.rlow !== want.rlow || got.rhigh !== want.rhigh ||
                    got.did !== want.did || got.dlen !== want.dlen ||
                    got.addr !== want.addr || got.apend !== want.apend ||
                    got.epop !== want.epop || got.epnum !== want.epnum ||
                    got.dstate !== want.dstate)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_usb_standard_request_handler NOT OK");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_pct = 30;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = '0;
        request_type = '0;
        request_code = '0;
        value_word = '0;
        index_word = '0;
        length_word = '0;
        data_byte = '0;
        mdl_own_power = 1'b0;
        mdl_dev_len = 8'd18;
        mdl_cfg_len = 8'd39;
        mdl_lang_len = 8'd4;
        mdl_str1_len = 8'd0;
        mdl_str2_len = 8'd0;
        mdl_state = ST_DEFAULT;
        mdl_wakeup = 1'b0;
        mdl_halts = 3'd0;
        mdl_bargraph = 8'd0;
        mdl_segment = 8'd0;
        mdl_switch = 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        load_settings(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        test_directed();
        test_pause();
        load_settings(1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        test_enumeration(30);
        load_settings(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
        test_enumeration(40);
        idle_pct = 0;
        test_random(400);
        idle_pct = 30;
        load_settings(1'b0, 8'd18, 8'd39, 8'd4, 8'd26, 8'd130);
        test_enumeration(25);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_usb_standard_request_handler OK");
        else
            $display("tb_usb_standard_request_handler NOT OK");
        $finish;
    end

endmodule
